FILE: rtl/pcst_pkg.sv
package pcst_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 11;
    localparam int CH_BITS       = 4;
    localparam int CNT_BITS      = 5;
    localparam int CLIP_BITS     = 15;
    localparam int SUM_BITS      = 40;
    localparam int COUNT_BITS    = 25;
    localparam int WIDE_BITS     = SUM_BITS + 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int CHANNELS_DEF  = 16;
    localparam int DIV_STEPS     = SUM_BITS;
    // guard limits: count above 2^24, |sum| above 2^24 volts
    localparam int COUNT_LIM_LOG = 24;
    localparam int SUM_LIM_LOG   = 24 + FRAC_BITS;

    localparam logic [CLIP_BITS-1:0]     CLIP_RESET = 15'd20480;
    localparam logic signed [SAMPLE_BITS-1:0] TRIG_LO_RESET = 16'sd0;
    localparam logic signed [SAMPLE_BITS-1:0] TRIG_HI_RESET = 16'sd2048;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_start;
        logic                          frame_end;
        logic [CNT_BITS-1:0]           channel_count;
        logic signed [SAMPLE_BITS-1:0] reset_level;
        logic                          reset_present;
    } t_in_word;

    typedef struct packed {
        logic [CH_BITS-1:0]            out_channel;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic signed [SAMPLE_BITS-1:0] nearest_zero;
        logic signed [SAMPLE_BITS-1:0] furthest_zero;
        logic signed [SAMPLE_BITS-1:0] average;
        logic signed [SAMPLE_BITS-1:0] range_or_sum;
    } t_out_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic signed [SAMPLE_BITS-1:0] nearest;
        logic signed [SAMPLE_BITS-1:0] furthest;
        logic signed [SUM_BITS-1:0]    sum;
        logic [COUNT_BITS-1:0]         count;
    } t_slot;

    typedef struct packed {
        logic clear_all;
        logic clear_zero;
        logic write;
    } t_slot_ctl;

    typedef struct packed {
        logic ready;
        logic frame_step;
        logic update;
        logic emit;
    } t_fsm_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME,
        ST_UPDATE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POLY_MODE     = 3'd0,
        CFG_RESET_EVERY   = 3'd1,
        CFG_SUM_NOT_RANGE = 3'd2,
        CFG_CLIP_LIMIT    = 3'd3,
        CFG_TRIGGER_LOW   = 3'd4,
        CFG_TRIGGER_HIGH  = 3'd5
    } t_cfg_idx;

    function automatic logic [SAMPLE_BITS:0] iabs(input logic signed [SAMPLE_BITS-1:0] x);
        logic signed [SAMPLE_BITS:0] e;
        e = {x[SAMPLE_BITS-1], x};
        return e[SAMPLE_BITS] ? -e : e;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp(
        input logic signed [WIDE_BITS-1:0] v,
        input logic [CLIP_BITS-1:0]        clip
    );
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = $signed({{(WIDE_BITS-CLIP_BITS){1'b0}}, clip});
        lo = -hi;
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: rtl/pcst_div.sv
// Restoring divider, one quotient bit per cycle.
module pcst_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pcst_pkg::SUM_BITS-1:0]    i_dividend,
    input  logic [pcst_pkg::COUNT_BITS-1:0]  i_divisor,
    output logic                             o_busy,
    output logic [pcst_pkg::SUM_BITS-1:0]    o_quotient
);

    localparam int QW     = pcst_pkg::SUM_BITS;
    localparam int DW     = pcst_pkg::COUNT_BITS;
    localparam int STEP_W = $clog2(pcst_pkg::DIV_STEPS + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DW-1:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [DW-1:0]     r_div;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          take;

    always_comb begin
        shifted = {r_rem, r_quo[QW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        take    = !diff[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(pcst_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[DW-1:0] : shifted[DW-1:0];
            r_quo <= {r_quo[QW-2:0], take};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pcst_slots.sv
// Per-channel stats slots; a slot without its valid bit reads as all zero.
module pcst_slots #(
    parameter int CHANNELS = pcst_pkg::CHANNELS_DEF,
    parameter int SLOT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcst_pkg::t_slot_ctl   i_ctl,
    input  logic [SLOT_W-1:0]     i_addr,
    input  pcst_pkg::t_slot       i_wdata,
    output pcst_pkg::t_slot       o_rdata
);

    logic [CHANNELS-1:0] r_valid;
    pcst_pkg::t_slot     r_data [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear_all) begin
            r_valid <= '0;
        end else if (i_ctl.clear_zero) begin
            r_valid[0] <= 1'b0;
        end else if (i_ctl.write) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_data[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_valid[i_addr] ? r_data[i_addr] : '0;

endmodule

FILE: rtl/poly_channel_stats_tracker.sv
// Running min / max / nearest-to-zero / furthest-from-zero / mean tracker over
// frames of up to CHANNELS signed Q5.11 samples, one sample per input word.
// Poly mode keeps one slot per channel and returns a result word for every
// in-range sample; mono mode pools the frame into slot 0 and returns one word
// at frame end. Stats reset every frame or on a Schmitt-triggered rising
// reset level read at frame start; a change of poly mode or channel count
// clears every slot. Timing: a word that yields no result passes the frame and
// update states before the next can be taken (only the frame state for an
// empty frame or a poly channel beyond CHANNELS); a word that yields a result
// also waits in the divide state for the bit-serial divider of the average (one
// quotient bit per cycle over the 40-bit sum), then in the emit state until the
// output is free. The input stalls while a word is in flight; a finished
// result sits in the output register and does not block the next input, but
// a second result holds in the emit state until the first is taken.
// Slots are cleared through per-slot valid bits, so no clearing pass is run.
// Config writes are taken at any cycle and must only be issued while idle.
module poly_channel_stats_tracker #(
    parameter int CHANNELS = pcst_pkg::CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    input  pcst_pkg::t_in_word                   i_in_word,
    output logic                                 o_in_stall,
    // result words
    output logic                                 o_out_valid,
    output pcst_pkg::t_out_word                  o_out_word,
    input  logic                                 i_out_stall,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [pcst_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pcst_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SB     = pcst_pkg::SAMPLE_BITS;
    localparam int SUMB   = pcst_pkg::SUM_BITS;
    localparam int CNTB   = pcst_pkg::COUNT_BITS;
    localparam int WB     = pcst_pkg::WIDE_BITS;
    localparam int CHW    = pcst_pkg::CH_BITS + 1;
    localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [CHW-1:0]  CH_LIMIT  = CHW'(CHANNELS);
    localparam logic [CNTB-1:0] COUNT_LIM = CNTB'(1) << pcst_pkg::COUNT_LIM_LOG;
    localparam logic [SUMB-1:0] SUM_LIM   = SUMB'(1) << pcst_pkg::SUM_LIM_LOG;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic                                   r_poly;
    logic                                   r_every;
    logic                                   r_snr;
    logic [pcst_pkg::CLIP_BITS-1:0]         r_clip;
    logic signed [SB-1:0]                   r_trig_lo;
    logic signed [SB-1:0]                   r_trig_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly    <= 1'b0;
            r_every   <= 1'b1;
            r_snr     <= 1'b0;
            r_clip    <= pcst_pkg::CLIP_RESET;
            r_trig_lo <= pcst_pkg::TRIG_LO_RESET;
            r_trig_hi <= pcst_pkg::TRIG_HI_RESET;
        end else if (i_cfg_we) begin
            case (pcst_pkg::t_cfg_idx'(i_cfg_index))
                pcst_pkg::CFG_POLY_MODE:     r_poly    <= i_cfg_data[0];
                pcst_pkg::CFG_RESET_EVERY:   r_every   <= i_cfg_data[0];
                pcst_pkg::CFG_SUM_NOT_RANGE: r_snr     <= i_cfg_data[0];
                pcst_pkg::CFG_CLIP_LIMIT:    r_clip    <= i_cfg_data[pcst_pkg::CLIP_BITS-1:0];
                pcst_pkg::CFG_TRIGGER_LOW:   r_trig_lo <= $signed(i_cfg_data[SB-1:0]);
                pcst_pkg::CFG_TRIGGER_HIGH:  r_trig_hi <= $signed(i_cfg_data[SB-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    pcst_pkg::t_state   r_state;
    pcst_pkg::t_state   n_state;
    pcst_pkg::t_fsm_out fsm;

    pcst_pkg::t_in_word r_in;
    logic               r_fresh;
    logic               n_fresh;
    logic               r_trig;
    logic               n_trig;
    logic [pcst_pkg::CNT_BITS-1:0] r_prev_cnt;
    logic               r_prev_poly;
    logic               r_avg_neg;
    logic               r_out_valid;
    pcst_pkg::t_out_word r_out_word;

    logic               div_busy;
    logic [SUMB-1:0]    div_quo;
    logic               div_start;

    logic               cnt_zero;
    logic               proc;
    logic               changed;
    logic               trig_fire;
    logic               rst_ev;
    logic               emit_req;
    logic               out_free;
    logic               emit_fire;
    logic [SLOT_W-1:0]  slot_addr;

    pcst_pkg::t_slot_ctl slot_ctl;
    pcst_pkg::t_slot     slot_rd;
    pcst_pkg::t_slot     slot_wr;
    pcst_pkg::t_slot     upd_rec;
    pcst_pkg::t_slot     guard_rec;
    pcst_pkg::t_out_word res;

    assign cnt_zero  = (r_in.channel_count == '0);
    assign proc      = !r_poly || ({1'b0, r_in.channel} < CH_LIMIT);
    assign slot_addr = r_poly ? r_in.channel[SLOT_W-1:0] : '0;
    assign changed   = r_in.frame_start &&
                       ((r_poly != r_prev_poly) || (r_in.channel_count != r_prev_cnt));
    // mono mode reports only at frame end
    assign emit_req  = r_poly || r_in.frame_end;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign emit_fire = fsm.emit && out_free;
    assign div_start = fsm.update && emit_req;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcst_pkg::ST_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    n_state = pcst_pkg::ST_FRAME;
                end
            end
            pcst_pkg::ST_FRAME: begin
                n_state = (cnt_zero || !proc) ? pcst_pkg::ST_IDLE : pcst_pkg::ST_UPDATE;
            end
            pcst_pkg::ST_UPDATE: begin
                n_state = emit_req ? pcst_pkg::ST_DIV : pcst_pkg::ST_IDLE;
            end
            pcst_pkg::ST_DIV: begin
                if (!div_busy) begin
                    n_state = pcst_pkg::ST_EMIT;
                end
            end
            pcst_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = pcst_pkg::ST_IDLE;
                end
            end
            default: n_state = pcst_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        fsm = '0;
        case (r_state)
            pcst_pkg::ST_IDLE:   fsm.ready      = 1'b1;
            pcst_pkg::ST_FRAME:  fsm.frame_step = 1'b1;
            pcst_pkg::ST_UPDATE: fsm.update     = 1'b1;
            pcst_pkg::ST_EMIT:   fsm.emit       = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = !fsm.ready || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (fsm.ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // ---------------------------------------------------------------
    // Frame start: change check, Schmitt trigger, reset events
    // ---------------------------------------------------------------
    always_comb begin
        n_trig    = r_trig;
        trig_fire = 1'b0;
        if (r_in.frame_start && !cnt_zero && !r_every && r_in.reset_present) begin
            if (r_trig) begin
                if (r_in.reset_level <= r_trig_lo) begin
                    n_trig = 1'b0;
                end
            end else if (r_in.reset_level >= r_trig_hi) begin
                n_trig    = 1'b1;
                trig_fire = 1'b1;
            end
        end
    end

    assign rst_ev = r_in.frame_start && !cnt_zero && (r_every || trig_fire);

    always_comb begin
        n_fresh = r_fresh;
        if (fsm.frame_step) begin
            if (changed || rst_ev) begin
                n_fresh = 1'b1;
            end
            // out-of-range poly channel: frame end still lands here
            if (r_in.frame_end && !cnt_zero && !proc) begin
                n_fresh = 1'b0;
            end
        end else if (fsm.update && r_in.frame_end) begin
            n_fresh = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh     <= 1'b1;
            r_trig      <= 1'b0;
            r_prev_cnt  <= '0;
            r_prev_poly <= 1'b0;
        end else begin
            r_fresh <= n_fresh;
            if (fsm.frame_step) begin
                r_trig <= n_trig;
                if (changed) begin
                    r_prev_cnt  <= r_in.channel_count;
                    r_prev_poly <= r_poly;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Slot update and overflow guard
    // ---------------------------------------------------------------
    always_comb begin
        logic signed [SB-1:0] x;
        logic [SB:0]          ax;
        x       = r_in.sample;
        ax      = pcst_pkg::iabs(x);
        upd_rec = slot_rd;
        if (r_fresh && (r_in.channel == '0 || r_poly)) begin
            upd_rec.minimum  = x;
            upd_rec.maximum  = x;
            upd_rec.nearest  = x;
            upd_rec.furthest = x;
            upd_rec.sum      = SUMB'(x);
            upd_rec.count    = CNTB'(1);
        end else begin
            if (x < slot_rd.minimum) upd_rec.minimum = x;
            if (x > slot_rd.maximum) upd_rec.maximum = x;
            if (ax < pcst_pkg::iabs(slot_rd.nearest))  upd_rec.nearest  = x;
            if (ax > pcst_pkg::iabs(slot_rd.furthest)) upd_rec.furthest = x;
            upd_rec.sum   = slot_rd.sum + SUMB'(x);
            upd_rec.count = slot_rd.count + CNTB'(1);
        end
    end

    always_comb begin
        logic [SUMB-1:0] mag;
        mag       = slot_rd.sum[SUMB-1] ? SUMB'(-slot_rd.sum) : SUMB'(slot_rd.sum);
        guard_rec = slot_rd;
        if ((slot_rd.count > COUNT_LIM) || (mag > SUM_LIM)) begin
            guard_rec.sum   = slot_rd.sum >>> 1;
            guard_rec.count = slot_rd.count >> 1;
        end
    end

    always_comb begin
        slot_ctl.clear_all  = fsm.frame_step && (changed || (rst_ev && r_poly));
        slot_ctl.clear_zero = fsm.frame_step && rst_ev && !r_poly;
        slot_ctl.write      = fsm.update || emit_fire;
        slot_wr             = fsm.update ? upd_rec : guard_rec;
    end

    pcst_slots #(
        .CHANNELS (CHANNELS),
        .SLOT_W   (SLOT_W)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (slot_ctl),
        .i_addr  (slot_addr),
        .i_wdata (slot_wr),
        .o_rdata (slot_rd)
    );

    // ---------------------------------------------------------------
    // Average: |sum| / count through the single divider
    // ---------------------------------------------------------------
    pcst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (upd_rec.sum[SUMB-1] ? SUMB'(-upd_rec.sum) : SUMB'(upd_rec.sum)),
        .i_divisor  (upd_rec.count),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_avg_neg <= upd_rec.sum[SUMB-1];
        end
    end

    // ---------------------------------------------------------------
    // Result word and output register
    // ---------------------------------------------------------------
    always_comb begin
        logic signed [WB-1:0] avg;
        logic signed [WB-1:0] rs;
        if (slot_rd.count == '0) begin
            avg = '0;
        end else if (r_avg_neg) begin
            avg = -$signed({2'b00, div_quo});
        end else begin
            avg = $signed({2'b00, div_quo});
        end
        if (r_snr) begin
            rs = WB'(slot_rd.sum);
        end else begin
            rs = WB'(slot_rd.maximum) - WB'(slot_rd.minimum);
        end
        res.out_channel   = r_poly ? r_in.channel : '0;
        res.minimum       = pcst_pkg::clamp(WB'(slot_rd.minimum), r_clip);
        res.maximum       = pcst_pkg::clamp(WB'(slot_rd.maximum), r_clip);
        res.nearest_zero  = pcst_pkg::clamp(WB'(slot_rd.nearest), r_clip);
        res.furthest_zero = pcst_pkg::clamp(WB'(slot_rd.furthest), r_clip);
        res.average       = pcst_pkg::clamp(avg, r_clip);
        res.range_or_sum  = pcst_pkg::clamp(rs, r_clip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == pcst_pkg::ST_DIV))
        else $error("divider busy outside divide state");

    a_update_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcst_pkg::ST_UPDATE) |-> (proc && !cnt_zero))
        else $error("slot update for an out-of-range channel or empty frame");

    a_out_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fire |=> (o_out_valid &&
            (o_out_word.out_channel == ($past(r_poly) ? $past(r_in.channel) : '0))))
        else $error("result word carries the wrong channel");

    a_avg_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((WB'(o_out_word.average) <= $signed(WB'(r_clip))) &&
                         (WB'(o_out_word.average) >= -$signed(WB'(r_clip)))))
        else $error("average outside the clip limit");

endmodule
